// ===== hw/rtl/lpr_pkg.sv =====
package lpr_pkg;

  // Table geometry
  localparam int MAX_FRAMES = 16;
  localparam int FRAME_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int RANK_W     = FRAME_W;

  // Field widths
  localparam int PAGE_W  = 16;
  localparam int IDX_W   = 4;
  localparam int FAULT_W = 32;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(16);
  localparam logic [RANK_W-1:0]  RANK_MAX  = RANK_W'(MAX_FRAMES - 1);
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  typedef logic [PAGE_W-1:0]     page_t;
  typedef logic [FRAME_W-1:0]    frame_t;
  typedef logic [RANK_W-1:0]     rank_t;
  typedef logic [MAX_FRAMES-1:0] fmask_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] frame_index;
    logic             evicted_valid;
    page_t            evicted_page;
    logic [FAULT_W-1:0] fault_count;
  } result_t;

  typedef enum logic {
    ST_LOOK,
    ST_COMMIT
  } back_state_t;

  // Keep only the lowest set bit
  function automatic fmask_t lowest_onehot(input fmask_t v);
    return v & fmask_t'(~v + fmask_t'(1));
  endfunction

  // Encode a one-hot (or zero) mask into a frame number
  function automatic frame_t onehot_to_idx(input fmask_t v);
    frame_t r;
    r = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (v[i]) r = r | frame_t'(i);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/lpr_front.sv =====
module lpr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  lpr_pkg::page_t page_number,
  output logic           q_valid,
  output lpr_pkg::page_t q_page,
  input  logic           q_pop
);
  import lpr_pkg::*;

  page_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr_en;
  logic       rd_en;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_page  = slot[rd_ptr];
  assign wr_en   = push && !full;
  assign rd_en   = q_pop && q_valid;

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Hold incoming pages
  always_ff @(posedge clk) begin
    if (wr_en) slot[wr_ptr] <= page_number;
  end

endmodule

// ===== hw/rtl/lpr_back.sv =====
module lpr_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [lpr_pkg::CFG_W-1:0] cfg_data,
  input  logic                   q_valid,
  input  lpr_pkg::page_t         q_page,
  output logic                   q_pop,
  input  logic                   out_full,
  output logic                   res_wr,
  output lpr_pkg::result_t       res
);
  import lpr_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [CFG_W-1:0]   frames_in_use;
  logic [CNT_W-1:0]   n_active;
  fmask_t             in_use;

  page_t              frame_page [MAX_FRAMES];
  fmask_t             frame_valid;
  rank_t              rank [MAX_FRAMES];
  logic [FAULT_W-1:0] faults_total;
  logic [FAULT_W-1:0] faults_next;

  fmask_t match;
  fmask_t empty_m;
  fmask_t lru_m;
  logic   look_hit;
  logic   look_evict;
  frame_t look_frame;

  // Classification of the item in flight
  frame_t f_q;
  logic   hit_q;
  logic   evict_q;
  page_t  page_q;

  logic   was_valid;
  rank_t  old_rank;
  logic   look_en;

  // Clamp the frame count to one .. MAX_FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      n_active = CNT_W'(1);
    end else if (32'(frames_in_use) > MAX_FRAMES) begin
      n_active = CNT_W'(MAX_FRAMES);
    end else begin
      n_active = CNT_W'(frames_in_use);
    end
    for (int i = 0; i < MAX_FRAMES; i++) begin
      in_use[i] = (32'(i) < 32'(n_active));
    end
  end

  // Look up the page, find empty frames and the least recent frame
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      match[i]   = in_use[i] && frame_valid[i] && (frame_page[i] == q_page);
      empty_m[i] = in_use[i] && !frame_valid[i];
      lru_m[i]   = in_use[i];
      for (int j = 0; j < MAX_FRAMES; j++) begin
        if (j != i && in_use[j]) begin
          // ties go to the lower frame
          if (j < i) begin
            if (!(rank[i] > rank[j])) lru_m[i] = 1'b0;
          end else begin
            if (rank[i] < rank[j]) lru_m[i] = 1'b0;
          end
        end
      end
    end
    look_hit   = |match;
    look_evict = 1'b0;
    if (look_hit) begin
      look_frame = onehot_to_idx(lowest_onehot(match));
    end else if (|empty_m) begin
      look_frame = onehot_to_idx(lowest_onehot(empty_m));
    end else begin
      look_frame = onehot_to_idx(lowest_onehot(lru_m));
      look_evict = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOOK:   if (q_valid) state_next = ST_COMMIT;
      ST_COMMIT: if (!out_full) state_next = ST_LOOK;
      default:   state_next = ST_LOOK;
    endcase
  end

  // Handshake outputs
  always_comb begin
    q_pop  = 1'b0;
    res_wr = 1'b0;
    unique case (state)
      ST_LOOK:   q_pop  = q_valid;
      ST_COMMIT: res_wr = !out_full;
      default: begin
        q_pop  = 1'b0;
        res_wr = 1'b0;
      end
    endcase
  end

  assign look_en   = q_pop;
  assign was_valid = hit_q || evict_q;
  assign old_rank  = rank[f_q];

  // Saturating fault count including this item
  always_comb begin
    faults_next = faults_total;
    if (!hit_q && faults_total != FAULT_MAX) faults_next = faults_total + FAULT_W'(1);
  end

  // Build the result
  always_comb begin
    res.hit           = hit_q;
    res.frame_index   = IDX_W'(f_q);
    res.evicted_valid = evict_q;
    res.evicted_page  = evict_q ? frame_page[f_q] : '0;
    res.fault_count   = faults_next;
  end

  // Control state, recency ranks and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOOK;
      frames_in_use <= CFG_RESET;
      frame_valid   <= '0;
      faults_total  <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) rank[i] <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) frames_in_use <= cfg_data;
      if (res_wr) begin
        faults_total <= faults_next;
        for (int i = 0; i < MAX_FRAMES; i++) begin
          if (frame_t'(i) == f_q) begin
            rank[i]        <= '0;
            frame_valid[i] <= 1'b1;
          end else if (in_use[i] && frame_valid[i] && (!was_valid || rank[i] < old_rank)
                       && rank[i] != RANK_MAX) begin
            rank[i] <= rank[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  // Hold the classification and write the new page
  always_ff @(posedge clk) begin
    if (look_en) begin
      f_q     <= look_frame;
      hit_q   <= look_hit;
      evict_q <= look_evict;
      page_q  <= q_page;
    end
    if (res_wr && !hit_q) frame_page[f_q] <= page_q;
  end

endmodule

// ===== hw/rtl/lpr_out.sv =====
module lpr_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_wr,
  input  lpr_pkg::result_t res,
  output logic             out_full,
  input  logic             pop,
  output logic             empty,
  output lpr_pkg::result_t head
);
  import lpr_pkg::*;

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr_en;
  logic       rd_en;

  assign out_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign head     = slot[rd_ptr];
  assign wr_en    = res_wr && !out_full;
  assign rd_en    = pop && !empty;

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Hold finished results
  always_ff @(posedge clk) begin
    if (wr_en) slot[wr_ptr] <= res;
  end

endmodule

// ===== hw/rtl/lru_page_replacement.sv =====
// A pushed page passes the input queue, the lookup and the table update before its result
// reaches the result queue (empty low); the lookup and the update are separate steps,
// and the next lookup waits for the update, which stalls while the result queue is full.
// Input and result queues hold two items each, so either side may stall alone.
// Reset (rst, synchronous, active high) empties both queues, clears all frames
// and the fault count, and sets the frame count to sixteen.
module lru_page_replacement (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [15:0]               page_number,
  input  logic                      pop,
  output logic                      empty,
  output logic                      hit,
  output logic [3:0]                frame_index,
  output logic                      evicted_valid,
  output logic [15:0]               evicted_page,
  output logic [31:0]               fault_count,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lpr_pkg::CFG_W-1:0] cfg_data
);
  import lpr_pkg::*;

  logic    q_valid;
  page_t   q_page;
  logic    q_pop;
  logic    out_full;
  logic    res_wr;
  result_t res;
  result_t head;

  assign cfg_ready = 1'b1;

  lpr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .page_number (page_number),
    .q_valid     (q_valid),
    .q_page      (q_page),
    .q_pop       (q_pop)
  );

  lpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_page    (q_page),
    .q_pop     (q_pop),
    .out_full  (out_full),
    .res_wr    (res_wr),
    .res       (res)
  );

  lpr_out u_out (
    .clk      (clk),
    .rst      (rst),
    .res_wr   (res_wr),
    .res      (res),
    .out_full (out_full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  assign hit           = head.hit;
  assign frame_index   = head.frame_index;
  assign evicted_valid = head.evicted_valid;
  assign evicted_page  = head.evicted_page;
  assign fault_count   = head.fault_count;

  // Never write a result into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_wr |-> !out_full)
    else $error("result written into full queue");

  // A hit replaces nothing
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    res_wr && res.hit |-> !res.evicted_valid)
    else $error("hit reported with eviction");

  // No eviction reports page zero
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    res_wr && !res.evicted_valid |-> res.evicted_page == '0)
    else $error("evicted page not zero without eviction");

  // A lookup is followed by exactly one commit before the next lookup
  a_pop_then_commit: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> !q_pop)
    else $error("second lookup before commit");

endmodule
